// File: hw/rtl/fq2sh_pkg.sv
// shared types, character codes and helper functions for the form query to
// shell assignment decoder; no dependencies
package fq2sh_pkg;

  // default longest accepted name, in bytes (1 to 32 fits its results in RESULT_CAP)
  localparam int NAME_MAX_DEFAULT = 32;
  // most results one input byte may produce
  localparam int RESULT_CAP = 34;
  localparam int CNT_W = 6;

  // result status codes
  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_NO_EQ    = 2'd1;
  localparam logic [1:0] ST_BAD_NAME = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_USCR  = 8'h5F;
  localparam logic [7:0] CH_BTICK = 8'h60;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  // decoder phase
  typedef enum logic [4:0] {
    PH_NAME  = 5'b00001,
    PH_VALUE = 5'b00010,
    PH_HEX1  = 5'b00100,
    PH_HEX2  = 5'b01000,
    PH_STOP  = 5'b10000
  } phase_t;

  // controller states; the emitting states also select the output byte
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_EXEC  = 8'b00000010,
    S_STAT  = 8'b00000100,
    S_NAME  = 8'b00001000,
    S_EQ    = 8'b00010000,
    S_APOS  = 8'b00100000,
    S_VAL   = 8'b01000000,
    S_CLOSE = 8'b10000000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic   load;       // input transaction taken
    logic   exec;       // decode the held byte
    logic   fire;       // push one result into the output register
    logic   final_res;  // this result ends the run
    state_t kind;       // which result is being pushed
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic do_status;
    logic do_name;
    logic do_value;
    logic do_close;
    logic name_last;
    logic val_last;
    logic close_last;
    logic cap_hit;
  } dp_sts_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
    return d;
  endfunction

  function automatic logic is_unsafe(input logic [7:0] c);
    return c inside {CH_AMP, CH_SEMI, CH_BTICK, CH_APOS, CH_DQUOT, CH_PIPE, CH_STAR,
                     CH_LT, CH_GT, CH_CARET, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK,
                     CH_LBRC, CH_RBRC, CH_DOLL, CH_LF, CH_CR, CH_BSL};
  endfunction

  function automatic logic is_name_char(input logic [7:0] c, input logic first);
    logic alpha;
    logic digit;
    alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    digit = (c >= 8'h30 && c <= 8'h39);
    return alpha || (c == CH_USCR) || (!first && digit);
  endfunction

endpackage

// File: hw/rtl/fq2sh_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module fq2sh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/fq2sh_ctrl.sv
// controller state machine: accepts a byte, runs the decode step, then
// walks the results one byte per cycle when the slot is free; uses fq2sh_pkg
module fq2sh_ctrl
  import fq2sh_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;
  logic   emitting;
  logic   fire;
  logic   fin;

  assign in_tready = (state_r == S_IDLE);
  assign emitting  = (state_r != S_IDLE) && (state_r != S_EXEC);
  assign fire      = emitting && sts.slot_free;

  // does the current result end the run
  always_comb begin
    case (state_r)
      S_STAT:  fin = 1'b1;
      S_APOS:  fin = !sts.do_value && !sts.do_close;
      S_VAL:   fin = sts.val_last && !sts.do_close;
      S_CLOSE: fin = sts.close_last;
      default: fin = 1'b0;
    endcase
    fin = fin || sts.cap_hit;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.do_status)     state_nxt = S_STAT;
        else if (sts.do_name)  state_nxt = S_NAME;
        else if (sts.do_value) state_nxt = S_VAL;
        else if (sts.do_close) state_nxt = S_CLOSE;
        else                   state_nxt = S_IDLE;
      end
      default: begin
        if (fire) begin
          if (fin) begin
            state_nxt = S_IDLE;
          end else begin
            case (state_r)
              S_NAME:  state_nxt = sts.name_last ? S_EQ : S_NAME;
              S_EQ:    state_nxt = S_APOS;
              S_APOS:  state_nxt = sts.do_value ? S_VAL : S_CLOSE;
              S_VAL:   state_nxt = sts.val_last ? S_CLOSE : S_VAL;
              S_CLOSE: state_nxt = S_CLOSE;
              default: state_nxt = S_IDLE;
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands to the datapath
  assign cmd.load      = in_tvalid && in_tready;
  assign cmd.exec      = (state_r == S_EXEC);
  assign cmd.fire      = fire;
  assign cmd.final_res = fin;
  assign cmd.kind      = state_r;

endmodule

// File: hw/rtl/fq2sh_dp.sv
// datapath: decoder phase, name store, result plan, sequence counters and
// output register; uses fq2sh_pkg and fq2sh_ram
module fq2sh_dp
  import fq2sh_pkg::*;
#(
  parameter int NAME_MAX = NAME_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       cfg_valid,
  input  logic       cfg_data,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic [1:0] out_tuser
);

  localparam int LW = $clog2(NAME_MAX + 1);
  localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

  // held input transaction
  logic [7:0]    byte_r;
  logic          last_r;
  logic          escape_en_r, escape_en_nxt;

  // decoder state
  phase_t        phase_r, phase_nxt;
  logic [LW-1:0] name_len_r, name_len_nxt;
  logic          name_valid_r, name_valid_nxt;
  logic [3:0]    hex_hi_r, hex_hi_nxt;

  // result plan for the current transaction
  logic          do_status_r, do_status_nxt;
  logic [1:0]    st_code_r, st_code_nxt;
  logic          do_name_r, do_name_nxt;
  logic          do_value_r, do_value_nxt;
  logic [7:0]    vbyte_r, vbyte_nxt;
  logic          do_close_r, do_close_nxt;
  logic [LW-1:0] dump_len_r, dump_len_nxt;

  // sequence counters
  logic [LW-1:0]    name_idx_r, name_idx_nxt;
  logic [1:0]       val_step_r, val_step_nxt;
  logic [1:0]       close_step_r, close_step_nxt;
  logic [CNT_W-1:0] res_cnt_r, res_cnt_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] out_user_r, out_user_nxt;

  logic       store_we;
  logic [7:0] store_rdata;
  logic       esc;
  logic [7:0] emit_byte;
  logic [1:0] emit_user;

  // name store
  fq2sh_ram #(
    .WIDTH (8),
    .DEPTH (NAME_MAX),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (name_len_r[AW-1:0]),
    .wdata (byte_r),
    .raddr (name_idx_nxt[AW-1:0]),
    .rdata (store_rdata)
  );

  // escape register
  always_comb begin
    escape_en_nxt = escape_en_r;
    if (cfg_valid) escape_en_nxt = cfg_data;
  end

  // decode step: primary action on the byte, then end of query handling
  always_comb begin
    phase_nxt      = phase_r;
    name_len_nxt   = name_len_r;
    name_valid_nxt = name_valid_r;
    hex_hi_nxt     = hex_hi_r;
    do_status_nxt  = do_status_r;
    st_code_nxt    = st_code_r;
    do_name_nxt    = do_name_r;
    do_value_nxt   = do_value_r;
    vbyte_nxt      = vbyte_r;
    do_close_nxt   = do_close_r;
    dump_len_nxt   = dump_len_r;
    store_we       = 1'b0;
    if (cmd.exec) begin
      do_status_nxt = 1'b0;
      st_code_nxt   = ST_DATA;
      do_name_nxt   = 1'b0;
      do_value_nxt  = 1'b0;
      vbyte_nxt     = byte_r;
      do_close_nxt  = 1'b0;
      dump_len_nxt  = name_len_r;
      case (phase_r)
        PH_NAME: begin
          if (byte_r == CH_AMP) begin
            if (name_len_r != '0) begin
              do_status_nxt = 1'b1;
              st_code_nxt   = ST_NO_EQ;
              phase_nxt     = PH_STOP;
            end
          end else if (byte_r == CH_EQ) begin
            if (name_len_r == '0 || !name_valid_r) begin
              do_status_nxt = 1'b1;
              st_code_nxt   = ST_BAD_NAME;
              phase_nxt     = PH_STOP;
            end else begin
              do_name_nxt = 1'b1;
              phase_nxt   = PH_VALUE;
            end
          end else if (name_len_r >= LW'(NAME_MAX)) begin
            name_valid_nxt = 1'b0;
          end else begin
            if (!is_name_char(byte_r, name_len_r == '0)) name_valid_nxt = 1'b0;
            store_we     = 1'b1;
            name_len_nxt = name_len_r + LW'(1);
          end
        end
        PH_VALUE: begin
          if (byte_r == CH_AMP) begin
            do_close_nxt   = 1'b1;
            phase_nxt      = PH_NAME;
            name_len_nxt   = '0;
            name_valid_nxt = 1'b1;
            hex_hi_nxt     = 4'd0;
          end else if (byte_r == CH_PLUS) begin
            do_value_nxt = 1'b1;
            vbyte_nxt    = CH_SPACE;
          end else if (byte_r == CH_PCT) begin
            phase_nxt = PH_HEX1;
          end else begin
            do_value_nxt = 1'b1;
          end
        end
        PH_HEX1: begin
          if (byte_r == CH_AMP) begin
            do_value_nxt   = 1'b1;
            vbyte_nxt      = CH_NUL;
            do_close_nxt   = 1'b1;
            phase_nxt      = PH_NAME;
            name_len_nxt   = '0;
            name_valid_nxt = 1'b1;
            hex_hi_nxt     = 4'd0;
          end else begin
            hex_hi_nxt = hex_digit(byte_r);
            phase_nxt  = PH_HEX2;
          end
        end
        PH_HEX2: begin
          do_value_nxt = 1'b1;
          if (byte_r == CH_AMP) begin
            vbyte_nxt      = {hex_hi_r, 4'd0};
            do_close_nxt   = 1'b1;
            phase_nxt      = PH_NAME;
            name_len_nxt   = '0;
            name_valid_nxt = 1'b1;
            hex_hi_nxt     = 4'd0;
          end else begin
            vbyte_nxt = {hex_hi_r, hex_digit(byte_r)};
            phase_nxt = PH_VALUE;
          end
        end
        default: begin
        end
      endcase
      // end of query closes whatever is open and returns to name collection
      if (last_r) begin
        case (phase_nxt)
          PH_NAME: begin
            if (name_len_nxt != '0) begin
              do_status_nxt = 1'b1;
              st_code_nxt   = ST_NO_EQ;
            end
          end
          PH_VALUE: begin
            do_close_nxt = 1'b1;
          end
          PH_HEX1: begin
            do_value_nxt = 1'b1;
            vbyte_nxt    = CH_NUL;
            do_close_nxt = 1'b1;
          end
          PH_HEX2: begin
            do_value_nxt = 1'b1;
            vbyte_nxt    = {hex_hi_nxt, 4'd0};
            do_close_nxt = 1'b1;
          end
          default: begin
          end
        endcase
        phase_nxt      = PH_NAME;
        name_len_nxt   = '0;
        name_valid_nxt = 1'b1;
        hex_hi_nxt     = 4'd0;
      end
    end
  end

  assign esc = escape_en_r && is_unsafe(vbyte_r);

  // sequence counters
  always_comb begin
    name_idx_nxt   = name_idx_r;
    val_step_nxt   = val_step_r;
    close_step_nxt = close_step_r;
    res_cnt_nxt    = res_cnt_r;
    if (cmd.exec) begin
      name_idx_nxt   = '0;
      val_step_nxt   = 2'd0;
      close_step_nxt = 2'd0;
      res_cnt_nxt    = '0;
    end else if (cmd.fire) begin
      res_cnt_nxt = res_cnt_r + CNT_W'(1);
      if (cmd.kind == S_NAME)  name_idx_nxt   = name_idx_r + LW'(1);
      if (cmd.kind == S_VAL)   val_step_nxt   = val_step_r + 2'd1;
      if (cmd.kind == S_CLOSE) close_step_nxt = close_step_r + 2'd1;
    end
  end

  // result byte and status for the current emitting state
  always_comb begin
    emit_byte = CH_NUL;
    emit_user = ST_DATA;
    case (cmd.kind)
      S_STAT:  emit_user = st_code_r;
      S_NAME:  emit_byte = store_rdata;
      S_EQ:    emit_byte = CH_EQ;
      S_APOS:  emit_byte = CH_APOS;
      S_VAL: begin
        if (!esc) begin
          emit_byte = vbyte_r;
        end else begin
          case (val_step_r)
            2'd0:    emit_byte = CH_APOS;
            2'd1:    emit_byte = CH_BSL;
            2'd2:    emit_byte = vbyte_r;
            default: emit_byte = CH_APOS;
          endcase
        end
      end
      S_CLOSE: begin
        case (close_step_r)
          2'd0:    emit_byte = CH_APOS;
          2'd1:    emit_byte = CH_SEMI;
          default: emit_byte = CH_LF;
        endcase
      end
      default: emit_byte = CH_NUL;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    if (cmd.fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_byte;
      out_last_nxt  = cmd.final_res;
      out_user_nxt  = emit_user;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_en_r  <= 1'b1;
      phase_r      <= PH_NAME;
      name_len_r   <= '0;
      name_valid_r <= 1'b1;
      hex_hi_r     <= 4'd0;
      do_status_r  <= 1'b0;
      do_name_r    <= 1'b0;
      do_value_r   <= 1'b0;
      do_close_r   <= 1'b0;
      name_idx_r   <= '0;
      val_step_r   <= 2'd0;
      close_step_r <= 2'd0;
      res_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      escape_en_r  <= escape_en_nxt;
      phase_r      <= phase_nxt;
      name_len_r   <= name_len_nxt;
      name_valid_r <= name_valid_nxt;
      hex_hi_r     <= hex_hi_nxt;
      do_status_r  <= do_status_nxt;
      do_name_r    <= do_name_nxt;
      do_value_r   <= do_value_nxt;
      do_close_r   <= do_close_nxt;
      name_idx_r   <= name_idx_nxt;
      val_step_r   <= val_step_nxt;
      close_step_r <= close_step_nxt;
      res_cnt_r    <= res_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
    st_code_r  <= st_code_nxt;
    vbyte_r    <= vbyte_nxt;
    dump_len_r <= dump_len_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  // status to the controller
  assign sts.slot_free  = !out_valid_r || out_tready;
  assign sts.do_status  = do_status_nxt;
  assign sts.do_name    = do_name_nxt;
  assign sts.do_value   = do_value_nxt;
  assign sts.do_close   = do_close_nxt;
  assign sts.name_last  = (LW'(name_idx_r + LW'(1)) == dump_len_r);
  assign sts.val_last   = !esc || (val_step_r == 2'd3);
  assign sts.close_last = (close_step_r == 2'd2);
  assign sts.cap_hit    = (res_cnt_r == CNT_W'(RESULT_CAP - 1));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  // an error result carries a zero byte and always ends its run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r != ST_DATA) |-> (out_data_r == CH_NUL && out_last_r))
    else $error("error result with data byte or open run");

  // the name never grows past its limit
  assert property (@(posedge clk) disable iff (!rst_n)
    name_len_r <= LW'(NAME_MAX))
    else $error("name length over limit");

  // a value is only open behind a valid, non-empty name
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_VALUE || phase_r == PH_HEX1 || phase_r == PH_HEX2)
      |-> (name_len_r != '0 && name_valid_r))
    else $error("value phase without a valid name");

  // no transaction produces more results than the cap
  assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= CNT_W'(RESULT_CAP))
    else $error("result count over cap");
`endif

endmodule

// File: hw/rtl/form_query_to_shell_assign_core.sv
// Form query to shell assignment decoder. Each accepted query byte is taken
// in the idle state and then decoded in the exec state; each result byte is
// then pushed by the controller into a one-deep output register, waiting
// while that register is full and out_tready is low.
// A data byte gives 1 result (4 when escaped), a pair end 3 more, and an
// equals sign after an N-byte name gives N + 2 results, the N name bytes
// read back from the name store one byte per cycle while the output
// register has room. At most 34 results come from one byte; any beyond
// that are dropped. The output register lets the next byte be accepted
// while the previous result still waits. There is no clearing pass after
// reset. Depends on fq2sh_pkg, fq2sh_ctrl and fq2sh_dp.
module form_query_to_shell_assign_core
  import fq2sh_pkg::*;
#(
  parameter int NAME_MAX = NAME_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  // query input
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_byte
  // shell text output
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // end_of_run
  output logic [1:0] out_tuser,  // [1:0] status
  // escape_enable register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  // controller
  fq2sh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath
  fq2sh_dp #(
    .NAME_MAX (NAME_MAX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
